// File: src/binary_greedy_slice_mesher_macros.svh
// Assertion macros for the binary greedy slice mesher.
// Included by the top level only; no other dependencies.
`ifndef BINARY_GREEDY_SLICE_MESHER_MACROS_SVH
`define BINARY_GREEDY_SLICE_MESHER_MACROS_SVH

// Same-cycle implication, quiet while reset is low.
`define BGSM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet while reset is low.
`define BGSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/bgsm_pkg.sv
// Shared types and constants of the binary greedy slice mesher.
// No dependencies; used by the run unit and the top level.
`default_nettype none

package bgsm_pkg;

  localparam int FIELD_W   = 6;   // width of the column, row and size result fields
  localparam int ROW_W     = 64;  // width of the row_bits input field
  localparam int ROW_IDX_W = 6;   // width of the row_index input field

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_SCAN  = 1'b1
  } action_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_LOAD = 5'b00010,
    ST_FIND = 5'b00100,
    ST_GROW = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  typedef struct packed {
    logic [FIELD_W-1:0] start_column;
    logic [FIELD_W-1:0] width_less_one;
  } run_desc_t;

endpackage

`default_nettype wire

// File: src/bgsm_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module bgsm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/bgsm_run_unit.sv
// Run extraction: isolates the lowest run of set bits and encodes a run mask
// into start column and width. Depends on bgsm_pkg.
`default_nettype none

module bgsm_run_unit #(
  parameter int W = 64
) (
  input  wire logic [W-1:0]          rem,
  input  wire logic [W-1:0]          run_mask,
  output      logic [W-1:0]          run,
  output      logic [W-1:0]          rest,
  output      bgsm_pkg::run_desc_t   desc
);

  localparam int AW = $clog2(W);

  logic [W-1:0]  low_bit;
  logic [W-1:0]  carry_sum;
  logic [W-1:0]  mask_low_oh;
  logic [W-1:0]  mask_top_oh;
  logic [AW-1:0] low_idx;
  logic [AW-1:0] top_idx;
  logic [AW-1:0] wm1;

  // Lowest run: adding its lowest bit carries through the run and clears it.
  assign low_bit   = rem & (~rem + W'(1));
  assign carry_sum = rem + low_bit;
  assign run       = rem & ~carry_sum;
  assign rest      = rem & ~run;

  // The mask is contiguous: its ends are one-hot.
  assign mask_low_oh = run_mask & (~run_mask + W'(1));
  assign mask_top_oh = run_mask & ~(run_mask >> 1);

  always_comb begin
    low_idx = '0;
    top_idx = '0;
    for (int i = 0; i < W; i++) begin
      if (mask_low_oh[i]) begin
        low_idx = low_idx | AW'(i);
      end
      if (mask_top_oh[i]) begin
        top_idx = top_idx | AW'(i);
      end
    end
  end

  assign wm1 = top_idx - low_idx;

  assign desc.start_column   = bgsm_pkg::FIELD_W'(low_idx);
  assign desc.width_less_one = bgsm_pkg::FIELD_W'(wm1);

endmodule

`default_nettype wire

// File: src/binary_greedy_slice_mesher.sv
// Binary greedy slice mesher: a write item gives no result, and the next item may follow on the
// next cycle. A scan item loads the row in LOAD, then per run takes it in FIND, grows it in GROW
// from the scanned row down the rows that hold the whole run mask, and emits it in EMIT, where
// it waits while the result register stays stalled. An empty row goes from LOAD to EMIT (a row
// outside the slice straight to EMIT) and gives one no-face result; input stalls until the last emit.
// Synchronous active-low reset clears the FSM, output valid and per-row valid bits; RAM keeps data.
`default_nettype none

`include "binary_greedy_slice_mesher_macros.svh"

module binary_greedy_slice_mesher #(
  parameter int SLICE_SIZE = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input channel
  input  wire logic                              in_valid,
  output      logic                              in_stall,
  input  wire logic                              in_action,
  input  wire logic [bgsm_pkg::ROW_IDX_W-1:0]    in_row_index,
  input  wire logic [bgsm_pkg::ROW_W-1:0]        in_row_bits,
  // result channel
  output      logic                              out_valid,
  input  wire logic                              out_stall,
  output      logic                              out_is_face,
  output      logic [bgsm_pkg::FIELD_W-1:0]      out_start_column,
  output      logic [bgsm_pkg::FIELD_W-1:0]      out_start_row,
  output      logic [bgsm_pkg::FIELD_W-1:0]      out_width_less_one,
  output      logic [bgsm_pkg::FIELD_W-1:0]      out_height_less_one,
  output      logic                              out_last
);

  localparam int W  = SLICE_SIZE;          // columns kept per row
  localparam int AW = $clog2(SLICE_SIZE);  // row address width
  localparam int CW = AW + 1;              // height counter, holds SLICE_SIZE itself
  localparam logic [bgsm_pkg::ROW_IDX_W:0] ROW_LIMIT = (bgsm_pkg::ROW_IDX_W + 1)'(SLICE_SIZE);
  localparam logic [AW-1:0] LAST_ROW = AW'(SLICE_SIZE - 1);

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  bgsm_pkg::state_t st_r, st_nxt;

  logic [bgsm_pkg::ROW_IDX_W-1:0] scan_row_r, scan_row_nxt;  // scanned row, full field width
  logic [W-1:0]  rem_r, rem_nxt;        // runs of the scanned row not yet handled
  logic [W-1:0]  run_r, run_nxt;        // mask of the run being grown
  logic [AW-1:0] grow_row_r, grow_row_nxt;
  logic [CW-1:0] height_r, height_nxt;  // rows covered so far
  logic          last_run_r, last_run_nxt;
  logic          noface_r, noface_nxt;

  // Per-row valid bits stand in for clearing the RAM at reset.
  logic [SLICE_SIZE-1:0] row_valid_r, row_valid_nxt;
  logic                  rd_valid_r, rd_valid_nxt;

  // Output register.
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_is_face_r, out_is_face_nxt;
  logic [bgsm_pkg::FIELD_W-1:0] out_col_r, out_col_nxt;
  logic [bgsm_pkg::FIELD_W-1:0] out_row_r, out_row_nxt;
  logic [bgsm_pkg::FIELD_W-1:0] out_wm1_r, out_wm1_nxt;
  logic [bgsm_pkg::FIELD_W-1:0] out_hm1_r, out_hm1_nxt;
  logic                        out_last_r, out_last_nxt;

  // ---------------------------------------------------------------------------
  // Slice RAM and run unit
  // ---------------------------------------------------------------------------
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [W-1:0]  ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [W-1:0]  ram_rdata;
  logic [W-1:0]  rd_row;     // read data with never-written rows forced to zero

  logic [W-1:0]        next_run;
  logic [W-1:0]        next_rest;
  bgsm_pkg::run_desc_t run_desc;

  bgsm_ram #(
    .WIDTH (W),
    .DEPTH (SLICE_SIZE)
  ) u_slice_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bgsm_run_unit #(
    .W (W)
  ) u_run_unit (
    .rem      (rem_r),
    .run_mask (run_r),
    .run      (next_run),
    .rest     (next_rest),
    .desc     (run_desc)
  );

  assign rd_row = rd_valid_r ? ram_rdata : '0;

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  logic in_accept;
  logic in_in_range;
  logic out_free;
  logic grow_hit;
  logic grow_more;

  assign in_stall    = (st_r != bgsm_pkg::ST_IDLE);
  assign in_accept   = in_valid && !in_stall;
  assign in_in_range = ({1'b0, in_row_index} < ROW_LIMIT);
  assign out_free    = !out_valid_r || !out_stall;

  // A later row extends the rectangle only if it holds the whole run mask.
  assign grow_hit  = ((rd_row & run_r) == run_r);
  assign grow_more = (grow_row_r != LAST_ROW);

  always_comb begin
    st_nxt        = st_r;
    scan_row_nxt  = scan_row_r;
    rem_nxt       = rem_r;
    run_nxt       = run_r;
    grow_row_nxt  = grow_row_r;
    height_nxt    = height_r;
    last_run_nxt  = last_run_r;
    noface_nxt    = noface_r;
    row_valid_nxt = row_valid_r;

    ram_we    = 1'b0;
    ram_waddr = in_row_index[AW-1:0];
    ram_wdata = in_row_bits[W-1:0];
    ram_re    = 1'b0;
    ram_raddr = in_row_index[AW-1:0];

    out_valid_nxt   = out_valid_r && out_stall;
    out_is_face_nxt = out_is_face_r;
    out_col_nxt     = out_col_r;
    out_row_nxt     = out_row_r;
    out_wm1_nxt     = out_wm1_r;
    out_hm1_nxt     = out_hm1_r;
    out_last_nxt    = out_last_r;

    unique case (st_r)
      bgsm_pkg::ST_IDLE: begin
        if (in_accept) begin
          scan_row_nxt = in_row_index;
          if (in_action == bgsm_pkg::ACT_WRITE) begin
            // Load the row; drop rows outside the slice.
            if (in_in_range) begin
              ram_we = 1'b1;
              row_valid_nxt[in_row_index[AW-1:0]] = 1'b1;
            end
          end else if (in_in_range) begin
            ram_re = 1'b1;
            st_nxt = bgsm_pkg::ST_LOAD;
          end else begin
            noface_nxt = 1'b1;
            st_nxt     = bgsm_pkg::ST_EMIT;
          end
        end
      end

      bgsm_pkg::ST_LOAD: begin
        // Snapshot the scanned row; its runs are all taken from this copy.
        rem_nxt    = rd_row;
        noface_nxt = (rd_row == '0);
        st_nxt     = (rd_row == '0) ? bgsm_pkg::ST_EMIT : bgsm_pkg::ST_FIND;
      end

      bgsm_pkg::ST_FIND: begin
        // Take the lowest remaining run and start growing from the scanned row.
        run_nxt      = next_run;
        rem_nxt      = next_rest;
        last_run_nxt = (next_rest == '0);
        height_nxt   = '0;
        grow_row_nxt = scan_row_r[AW-1:0];
        ram_re       = 1'b1;
        ram_raddr    = scan_row_r[AW-1:0];
        st_nxt       = bgsm_pkg::ST_GROW;
      end

      bgsm_pkg::ST_GROW: begin
        // Clear the mask in a covering row while the read of the next row is in flight.
        if (grow_hit) begin
          ram_we     = 1'b1;
          ram_waddr  = grow_row_r;
          ram_wdata  = rd_row & ~run_r;
          row_valid_nxt[grow_row_r] = 1'b1;
          height_nxt = height_r + CW'(1);
          if (grow_more) begin
            ram_re       = 1'b1;
            ram_raddr    = grow_row_r + AW'(1);
            grow_row_nxt = grow_row_r + AW'(1);
          end else begin
            st_nxt = bgsm_pkg::ST_EMIT;
          end
        end else begin
          st_nxt = bgsm_pkg::ST_EMIT;
        end
      end

      bgsm_pkg::ST_EMIT: begin
        // Hold until the output register is free, then hand over one result.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_row_nxt   = scan_row_r;
          if (noface_r) begin
            out_is_face_nxt = 1'b0;
            out_col_nxt     = '0;
            out_wm1_nxt     = '0;
            out_hm1_nxt     = '0;
            out_last_nxt    = 1'b1;
            noface_nxt      = 1'b0;
            st_nxt          = bgsm_pkg::ST_IDLE;
          end else begin
            out_is_face_nxt = 1'b1;
            out_col_nxt     = run_desc.start_column;
            out_wm1_nxt     = run_desc.width_less_one;
            out_hm1_nxt     = bgsm_pkg::FIELD_W'(AW'(height_r - CW'(1)));
            out_last_nxt    = last_run_r;
            st_nxt          = last_run_r ? bgsm_pkg::ST_IDLE : bgsm_pkg::ST_FIND;
          end
        end
      end

      default: begin
        st_nxt = bgsm_pkg::ST_IDLE;
      end
    endcase

    rd_valid_nxt = ram_re ? row_valid_r[ram_raddr] : rd_valid_r;
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= bgsm_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      row_valid_r <= '0;
      noface_r    <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      row_valid_r <= row_valid_nxt;
      noface_r    <= noface_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_row_r    <= scan_row_nxt;
    rem_r         <= rem_nxt;
    run_r         <= run_nxt;
    grow_row_r    <= grow_row_nxt;
    height_r      <= height_nxt;
    last_run_r    <= last_run_nxt;
    rd_valid_r    <= rd_valid_nxt;
    out_is_face_r <= out_is_face_nxt;
    out_col_r     <= out_col_nxt;
    out_row_r     <= out_row_nxt;
    out_wm1_r     <= out_wm1_nxt;
    out_hm1_r     <= out_hm1_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_is_face         = out_is_face_r;
  assign out_start_column    = out_col_r;
  assign out_start_row       = out_row_r;
  assign out_width_less_one  = out_wm1_r;
  assign out_height_less_one = out_hm1_r;
  assign out_last            = out_last_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `BGSM_ASSERT_NOW(a_first_row_hits, clk, rst_n,
    (st_r == bgsm_pkg::ST_GROW) && (height_r == '0), grow_hit,
    "scanned row does not hold its own run")
  `BGSM_ASSERT_NOW(a_no_rw_collision, clk, rst_n,
    ram_we && ram_re, ram_waddr != ram_raddr,
    "slice RAM read and write hit the same row")
  `BGSM_ASSERT_NOW(a_noface_is_last, clk, rst_n,
    out_valid && !out_is_face, out_last,
    "no-face result not marked last")

endmodule

`default_nettype wire
